[rtl/epoch_seconds_to_calendar_defines.svh]
// Assertion macros for the epoch seconds to calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

`ifndef SYNTHESIS

`define ES2CAL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ES2CAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ES2CAL_ASSERT_SAME(lbl, ante, cons, msg)

`define ES2CAL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/es2cal_pkg.sv]
// Constants and helper functions for the epoch seconds to calendar converter.
package es2cal_pkg;

  localparam logic [31:0] DAY_SECS  = 32'd86400;
  localparam logic [31:0] HOUR_SECS = 32'd3600;
  localparam logic [31:0] MIN_SECS  = 32'd60;
  localparam logic [31:0] WEEK_DAYS = 32'd7;
  localparam logic [31:0] LEAP_YEAR_DAYS   = 32'd366;
  localparam logic [31:0] COMMON_YEAR_DAYS = 32'd365;

  localparam logic [7:0] EPOCH_YEAR_OFS = 8'd70;   // 1970 - 1900
  localparam logic [7:0] LAST_YEAR_OFS  = 8'd206;
  localparam logic [3:0] LAST_MONTH     = 4'd11;
  localparam logic [3:0] FEB_INDEX      = 4'd1;
  localparam logic [2:0] EPOCH_WEEKDAY  = 3'd4;   // Thursday

  // 1970 reduced modulo 4, 100 and 400
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  // signed hours to seconds, x*3600 = x*(2048+1024+512+16)
  function automatic logic [31:0] tz_to_secs(input logic [4:0] tz);
    logic [31:0] ext;
    ext = {{27{tz[4]}}, tz};
    return (ext << 11) + (ext << 10) + (ext << 9) + (ext << 4);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/epoch_seconds_to_calendar.sv]
// Epoch seconds to Gregorian date and time of day, one shared subtractor.
// Restoring divisions for days, hours, minutes and weekday come first, then the
// year walk (one 365/366 subtraction per year, up to 136 years), then the month
// walk; the result then waits until the output register can take it. A new word
// is taken only after the last is converted, but a result may wait in the output
// register while the next word is taken. Synchronous active-high reset clears the
// sequencer, the output valid and the offset register (offset 0 hours).
`include "epoch_seconds_to_calendar_defines.svh"

module epoch_seconds_to_calendar
  import es2cal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,        // tz_hours, signed
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,     // [31:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] years_since_1900, [11:8] month_index, [16:12] day_of_month,
  // [21:17] hour_of_day, [27:22] minute_of_hour, [33:28] second_of_minute,
  // [36:34] weekday, [39:37] zero
  output logic [39:0] m_axis_tdata
);

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_DAY   = 3'd1;
  localparam logic [2:0] P_HOUR  = 3'd2;
  localparam logic [2:0] P_MIN   = 3'd3;
  localparam logic [2:0] P_WDAY  = 3'd4;
  localparam logic [2:0] P_YEAR  = 3'd5;
  localparam logic [2:0] P_MONTH = 3'd6;

  logic [2:0]  phase;
  logic [3:0]  k;
  logic [31:0] acc;
  logic [15:0] q;
  logic [15:0] days;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  wday;
  logic [7:0]  year;
  logic [3:0]  month;
  logic [1:0]  mod4;
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic [31:0] tz_secs;

  logic [7:0]  o_year;
  logic [3:0]  o_month;
  logic [4:0]  o_day;
  logic [4:0]  o_hour;
  logic [5:0]  o_minute;
  logic [5:0]  o_second;
  logic [2:0]  o_wday;
  logic        o_valid;

  logic [31:0] sub_val;
  logic [31:0] diff;
  logic        ge;
  logic [15:0] q_next;
  logic        leap;
  logic        out_free;
  logic        month_last;
  logic        load_out;
  logic        fields_ok;

  assign leap     = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign out_free = !o_valid || m_axis_tready;
  assign month_last = (month == LAST_MONTH) || !ge;
  assign load_out = (phase == P_MONTH) && month_last && out_free;

  // shared compare/subtract unit
  always_comb begin
    unique case (phase)
      P_DAY:   sub_val = DAY_SECS << k;
      P_HOUR:  sub_val = HOUR_SECS << k;
      P_MIN:   sub_val = MIN_SECS << k;
      P_WDAY:  sub_val = WEEK_DAYS << k;
      P_YEAR:  sub_val = leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
      P_MONTH: sub_val = {27'd0, month_len(month, leap)};
      default: sub_val = 32'd0;
    endcase
  end

  assign ge     = acc >= sub_val;
  assign diff   = acc - sub_val;
  assign q_next = ge ? (q | (16'd1 << k)) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      tz_secs <= 32'd0;
    end else if (cfg_we) begin
      tz_secs <= tz_to_secs(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= P_IDLE;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (s_axis_tvalid) begin
            acc   <= s_axis_tdata + tz_secs;
            k     <= 4'd15;
            q     <= 16'd0;
            phase <= P_DAY;
          end
        end
        P_DAY: begin
          if (ge) acc <= diff;
          if (k == 4'd0) begin
            days  <= q_next;
            q     <= 16'd0;
            k     <= 4'd4;
            phase <= P_HOUR;
          end else begin
            q <= q_next;
            k <= k - 4'd1;
          end
        end
        P_HOUR: begin
          if (ge) acc <= diff;
          if (k == 4'd0) begin
            hour  <= q_next[4:0];
            q     <= 16'd0;
            k     <= 4'd5;
            phase <= P_MIN;
          end else begin
            q <= q_next;
            k <= k - 4'd1;
          end
        end
        P_MIN: begin
          if (k == 4'd0) begin
            minute <= q_next[5:0];
            second <= ge ? diff[5:0] : acc[5:0];
            // (days + 4) mod 7 gives the weekday
            acc    <= {16'd0, days} + {29'd0, EPOCH_WEEKDAY};
            k      <= 4'd13;
            phase  <= P_WDAY;
          end else begin
            if (ge) acc <= diff;
            q <= q_next;
            k <= k - 4'd1;
          end
        end
        P_WDAY: begin
          if (k == 4'd0) begin
            wday   <= ge ? diff[2:0] : acc[2:0];
            acc    <= {16'd0, days};
            year   <= EPOCH_YEAR_OFS;
            mod4   <= EPOCH_MOD4;
            mod100 <= EPOCH_MOD100;
            mod400 <= EPOCH_MOD400;
            phase  <= P_YEAR;
          end else begin
            if (ge) acc <= diff;
            k <= k - 4'd1;
          end
        end
        P_YEAR: begin
          if (ge) begin
            acc    <= diff;
            year   <= year + 8'd1;
            mod4   <= mod4 + 2'd1;
            mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
            mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
          end else begin
            month <= 4'd0;
            phase <= P_MONTH;
          end
        end
        P_MONTH: begin
          if (!month_last) begin
            acc   <= diff;
            month <= month + 4'd1;
          end else if (out_free) begin
            // hold here until the output register can take the word
            o_year   <= year;
            o_month  <= month;
            o_day    <= acc[4:0] + 5'd1;
            o_hour   <= hour;
            o_minute <= minute;
            o_second <= second;
            o_wday   <= wday;
            phase    <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (phase == P_IDLE);
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {3'd0, o_wday, o_second, o_minute, o_hour, o_day, o_month, o_year};

  assign fields_ok = (o_day != 5'd0) && (o_hour < 5'd24) && (o_minute < 6'd60) &&
                     (o_second < 6'd60) && (o_wday < 3'd7);

  `ES2CAL_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, phase == P_DAY, "no start")
  `ES2CAL_ASSERT_SAME(a_year_range, phase == P_YEAR, year <= LAST_YEAR_OFS, "year past range")
  `ES2CAL_ASSERT_SAME(a_month_range, phase == P_MONTH, month <= LAST_MONTH, "month past Dec")
  `ES2CAL_ASSERT_SAME(a_out_fields, m_axis_tvalid, fields_ok, "result field out of range")

endmodule
